// ===== design/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // match scan: one chunk of CHUNK_W cells per cycle
    localparam int CHUNK_W     = 8;
    localparam int CHUNK_SEL_W = $clog2(CHUNK_W);
    localparam int CHUNKS      = (QUEUE_DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int CHUNK_IDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int SCAN_W      = CHUNKS * CHUNK_W;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_FIND = 2'd2,
        MODE_NOP  = 2'd3
    } mode_e;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_e;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_e;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] data_value;
        logic signed [31:0] priority_req;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         found_position;
        logic signed [31:0] head_value;
        logic [6:0]         entry_count;
    } out_beat_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               push;
        logic               find;
        logic signed [31:0] data;
        logic signed [31:0] prio;
    } cell_ctl_t;

    // what a cell shows its right-hand neighbor
    typedef struct packed {
        logic               lt;
        logic               occ;
        logic signed [31:0] data;
        logic signed [31:0] prio;
    } cell_link_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] pos;
    } find_res_t;

endpackage

// ===== design/spq_if.sv =====
// Valid/ready channel interfaces for request and response beats.
interface spq_in_if
    import spq_pkg::*;
();
    logic     valid;
    logic     ready;
    in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface spq_out_if
    import spq_pkg::*;
();
    logic      valid;
    logic      ready;
    out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/spq_cell.sv =====
// One queue slot: holds a data/priority pair and shifts right on insertion.
module spq_cell
    import spq_pkg::*;
(
    input  logic             clk,
    input  logic [IDX_W-1:0] idx,
    input  logic [CNT_W-1:0] count,
    input  cell_ctl_t        ctl,
    input  cell_link_t       left,
    output cell_link_t       right,
    output logic             match
);

    logic signed [31:0] data_reg;
    logic signed [31:0] prio_reg;
    logic               match_reg;
    logic               occ;
    logic               lt;

    assign occ = CNT_W'(idx) < count;
    // stays in place only when strictly ahead of the new priority
    assign lt  = occ && (prio_reg < ctl.prio);

    assign right.lt   = lt;
    assign right.occ  = occ;
    assign right.data = data_reg;
    assign right.prio = prio_reg;
    assign match      = match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            if (!lt && left.lt)
            begin
                data_reg <= ctl.data;
                prio_reg <= ctl.prio;
            end
            else if (!left.lt && left.occ)
            begin
                data_reg <= left.data;
                prio_reg <= left.prio;
            end
        end
        if (ctl.find)
            match_reg <= occ && (data_reg == ctl.data);
    end

endmodule

// ===== design/spq_finder.sv =====
// First-match search over the cell match flags, one chunk per cycle.
module spq_finder
    import spq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [QUEUE_DEPTH-1:0] match,
    output find_res_t              res
);

    logic                   busy_reg;
    logic                   done_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [CHUNK_IDX_W-1:0] chunk_reg;

    logic [SCAN_W-1:0]      padded;
    logic [CHUNK_W-1:0]     bits;
    logic [CHUNK_SEL_W-1:0] first;
    logic                   any;
    logic                   last;

    assign padded = SCAN_W'(match);
    assign bits   = padded[chunk_reg * CHUNK_W +: CHUNK_W];
    assign any    = |bits;
    assign last   = chunk_reg == CHUNK_IDX_W'(CHUNKS - 1);

    always_comb
    begin
        first = '0;
        for (int k = CHUNK_W - 1; k >= 0; k--)
        begin
            if (bits[k])
                first = CHUNK_SEL_W'(k);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            chunk_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            chunk_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (any || last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
                chunk_reg <= chunk_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            hit_reg <= any;
            pos_reg <= any ? IDX_W'({chunk_reg, first}) : '0;
        end
    end

    assign res.done = done_reg;
    assign res.hit  = hit_reg;
    assign res.pos  = pos_reg;

endmodule

// ===== design/sorted_priority_queue_top.sv =====
// Push/pop results are registered, in the cycle after the request beat; one
// such op per cycle while the response slot is free. Find scans the match
// flags one chunk of CHUNK_W cells per cycle; the next request waits for it.
// A new request is taken while the previous response beat is being taken.
// Reset empties the queue and drops any pending response; cell storage is
// not cleared and needs no clearing pass.
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    spq_in_if.sink        req,
    spq_out_if.source     rsp
);

    state_e     state_reg;
    state_e     state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    out_beat_t  out_beat_reg;
    out_beat_t  out_beat_next;

    cell_ctl_t  ctl;
    cell_link_t links [QUEUE_DEPTH + 1];
    logic [QUEUE_DEPTH-1:0] match;
    find_res_t  fres;

    logic       slot_free;
    logic       acc;
    logic       full;
    logic       empty;
    mode_e      mode;
    logic       push_ok;

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && slot_free;
    assign acc       = req.valid && req.ready;
    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign mode      = mode_e'(req.payload.mode);
    assign push_ok   = acc && (mode == MODE_PUSH) && !full;

    assign ctl.push = push_ok;
    assign ctl.find = acc && (mode == MODE_FIND);
    assign ctl.data = req.payload.data_value;
    assign ctl.prio = req.payload.priority_req;

    // left edge of the chain: an occupied slot that always stays ahead of the new entry
    assign links[0].lt   = 1'b1;
    assign links[0].occ  = 1'b1;
    assign links[0].data = '0;
    assign links[0].prio = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk   (clk),
            .idx   (IDX_W'(i)),
            .count (count_reg),
            .ctl   (ctl),
            .left  (links[i]),
            .right (links[i + 1]),
            .match (match[i])
        );
    end

    spq_finder u_finder (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.find),
        .match (match),
        .res   (fres)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_beat_next  = out_beat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    out_beat_next.status         = ST_OK;
                    out_beat_next.found_position = '0;
                    case (mode)
                        MODE_PUSH:
                        begin
                            if (full)
                                out_beat_next.status = ST_FULL;
                            else
                                count_next = count_reg + 1'b1;
                        end
                        MODE_POP:
                        begin
                            if (empty)
                                out_beat_next.status = ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        MODE_FIND:
                            state_next = S_SCAN;
                        default:
                            ;
                    endcase
                    out_beat_next.entry_count = 7'(count_next);
                    if (count_next == '0)
                        out_beat_next.head_value = '0;
                    else if (push_ok && !links[1].lt)
                        out_beat_next.head_value = req.payload.data_value;
                    else
                        out_beat_next.head_value = links[1].data;
                    if (mode != MODE_FIND)
                        out_valid_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (fres.done && slot_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_beat_next.status         = fres.hit ? ST_OK : ST_NOTFOUND;
                    out_beat_next.found_position = fres.hit ? 6'(fres.pos) : 6'd0;
                    out_beat_next.head_value     = empty ? '0 : links[1].data;
                    out_beat_next.entry_count    = 7'(count_reg);
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_beat_reg;

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks on the response channel, bound to the top level.
module spq_checker
    import spq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input out_beat_t rsp_beat
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_beat))
        else $error("response beat changed while stalled");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.entry_count == 7'd0) |-> rsp_beat.head_value == 32'sd0)
        else $error("empty queue reports nonzero head");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.status == ST_FULL) |->
            rsp_beat.entry_count == 7'(QUEUE_DEPTH))
        else $error("full status with queue not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.status == ST_EMPTY) |-> rsp_beat.entry_count == 7'd0)
        else $error("empty status with entries held");

    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_beat.status != ST_OK) |-> rsp_beat.found_position == 6'd0)
        else $error("position set on a failed step");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_beat  (rsp.payload)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted priority queue: directed, fill/drain and random runs.
module testbench
    import spq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n;

    spq_in_if  req_if ();
    spq_out_if rsp_if ();

    sorted_priority_queue_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #5 clk = ~clk;

    // Mirror of the queue contents, head at index 0
    logic signed [31:0] mirror_data [QUEUE_DEPTH];
    logic signed [31:0] mirror_prio [QUEUE_DEPTH];
    int                 mirror_count = 0;
    int                 peak_count   = 0;

    out_beat_t pending_results [$];

    int  err_count  = 0;
    int  checked    = 0;
    int  cycles     = 0;
    int  op_count   [4];
    int  stat_count [4];
    bit  tx_gaps    = 1'b1;
    bit  rx_gaps    = 1'b1;
    int  hold_ask   = 0;

    function automatic out_beat_t predict_queue_result(input in_beat_t beat);
        out_beat_t          res;
        logic signed [31:0] prio;
        int                 at;
        prio = beat.priority_req;
        res  = '0;
        res.status = ST_OK;
        case (mode_e'(beat.mode))
            MODE_PUSH:
                if (mirror_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    at = 0;
                    // equal numbers: new entry lands ahead of the existing ones
                    while (at < mirror_count && mirror_prio[at] < prio)
                        at++;
                    for (int i = mirror_count; i > at; i--) begin
                        mirror_data[i] = mirror_data[i-1];
                        mirror_prio[i] = mirror_prio[i-1];
                    end
                    mirror_data[at] = beat.data_value;
                    mirror_prio[at] = prio;
                    mirror_count++;
                end
            MODE_POP:
                if (mirror_count == 0)
                    res.status = ST_EMPTY;
                else
                    mirror_count--;
            MODE_FIND: begin
                res.status = ST_NOTFOUND;
                for (int i = 0; i < mirror_count; i++) begin
                    if (mirror_data[i] == beat.data_value) begin
                        res.status         = ST_OK;
                        res.found_position = i[5:0];
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.head_value  = (mirror_count > 0) ? mirror_data[0] : 32'sd0;
        res.entry_count = mirror_count[6:0];
        if (mirror_count > peak_count)
            peak_count = mirror_count;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 15)) - 8;
            1:
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            default: return $urandom;
        endcase
    endfunction

    task automatic send_op(input mode_e m, input logic signed [31:0] d,
                           input logic signed [31:0] p);
        in_beat_t  beat;
        out_beat_t res;
        beat.mode         = m;
        beat.data_value   = d;
        beat.priority_req = p;
        if (tx_gaps && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= beat;
        do @(posedge clk); while (!req_if.ready);
        res = predict_queue_result(beat);
        pending_results.push_back(res);
        op_count[m]++;
        stat_count[res.status]++;
    endtask

    task automatic random_ops(input int n, input int push_pct);
        int                 r;
        logic signed [31:0] d;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                send_op(MODE_PUSH, rand_word(), rand_word());
            end else if (r >= 97) begin
                send_op(MODE_NOP, rand_word(), rand_word());
            end else if (r % 2 == 0) begin
                send_op(MODE_POP, rand_word(), rand_word());
            end else begin
                if (mirror_count > 0 && $urandom_range(0, 9) < 6)
                    d = mirror_data[$urandom_range(0, mirror_count - 1)];
                else
                    d = rand_word();
                send_op(MODE_FIND, d, rand_word());
            end
        end
    endtask

    task automatic test_directed();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        send_op(MODE_POP,  32'sd0, 32'sd0);                 // pop on empty
        send_op(MODE_FIND, 32'sd0, 32'sd0);                 // find on empty
        send_op(MODE_NOP,  32'sh7fff_ffff, 32'sh8000_0000); // undefined mode, empty
        send_op(MODE_PUSH, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_op(MODE_PUSH, 32'sh8000_0000, 32'sh8000_0000); // goes to head
        send_op(MODE_PUSH, 32'sd1, 32'sd0);
        send_op(MODE_PUSH, 32'sd2, 32'sd0);                 // tie: ahead of data 1
        send_op(MODE_PUSH, 32'sd3, 32'sd0);
        send_op(MODE_FIND, 32'sd1, 32'sd0);
        send_op(MODE_FIND, 32'sh7fff_ffff, 32'sd0);
        send_op(MODE_FIND, 32'sd5, 32'sd0);                 // miss
        send_op(MODE_NOP,  -32'sd1, -32'sd1);
        send_op(MODE_PUSH, 32'sd2, -32'sd1);                // duplicate data
        send_op(MODE_FIND, 32'sd2, 32'sd0);                 // first match wins
        send_op(MODE_POP,  32'sd0, 32'sd0);
        send_op(MODE_POP,  32'sd0, 32'sd0);
        send_op(MODE_FIND, 32'sh8000_0000, 32'sd0);
        repeat (4) send_op(MODE_POP, 32'sd0, 32'sd0);
        send_op(MODE_POP,  32'sd0, 32'sd0);                 // empty again
    endtask

    task automatic test_fill_and_drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        // response side stalls long enough to back up the request side
        hold_ask = 300;
        repeat (QUEUE_DEPTH) send_op(MODE_PUSH, rand_word(), rand_word());
        send_op(MODE_PUSH, 32'sh7fff_ffff, 32'sh8000_0000);
        send_op(MODE_PUSH, 32'sh8000_0000, 32'sh7fff_ffff);
        send_op(MODE_FIND, mirror_data[QUEUE_DEPTH-1], 32'sd0);
        send_op(MODE_FIND, mirror_data[0], 32'sd0);
        send_op(MODE_FIND, 32'sh1234_5678, 32'sd0);
        repeat (QUEUE_DEPTH + 1) send_op(MODE_POP, 32'sd0, 32'sd0);
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 6; round++) begin
            tx_gaps = (round != 2);
            rx_gaps = (round != 4);
            random_ops(80, 80);
            random_ops((round % 3 == 2) ? 160 : 60, 5);
        end
    endtask

    task automatic test_quiet_tail();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        random_ops(60, 70);
        random_ops(60, 30);
    endtask

    // Response ready: random stall bursts, plus the long hold-off on request
    initial
    begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask > 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (!rx_gaps)
                rsp_if.ready <= 1'b1;
            else if (burst_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                burst_left--;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                rsp_if.ready <= 1'b0;
                burst_left = $urandom_range(0, 3);
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response beat with no request outstanding");
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (rsp_if.payload.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status,
                           rsp_if.payload.status);
                    err_count++;
                end
                if (rsp_if.payload.found_position !== want.found_position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.found_position, rsp_if.payload.found_position);
                    err_count++;
                end
                if (rsp_if.payload.head_value !== want.head_value)
                begin
                    $error("head_value: expected %0d, got %0d",
                           $signed(want.head_value), $signed(rsp_if.payload.head_value));
                    err_count++;
                end
                if (rsp_if.payload.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp_if.payload.entry_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n          <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix();
        test_quiet_tail();

        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("requests: %0d push, %0d pop, %0d find, %0d undefined; peak depth %0d",
                 op_count[MODE_PUSH], op_count[MODE_POP], op_count[MODE_FIND],
                 op_count[MODE_NOP], peak_count);
        $display("responses checked %0d: ok %0d, empty %0d, full %0d, not found %0d",
                 checked, stat_count[ST_OK], stat_count[ST_EMPTY],
                 stat_count[ST_FULL], stat_count[ST_NOTFOUND]);
        if (err_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
